FILE: design/sjpp_pkg.sv
// ----------------------------------------------------------------------------
// sjpp_pkg
// Shared constants, command type and arctangent table for the smoothed
// joystick polar packer.
// ----------------------------------------------------------------------------
package sjpp_pkg;

  // default sizes
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 9;
  localparam int MAG_BITS_DEF     = 6;

  // packed result word
  localparam int PACKED_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd1;

  // low-pass filter
  localparam int ALPHA_W = 9;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd205;
  localparam int FILT_ROUND = 128;
  localparam int FILT_SHIFT = 8;

  // cordic vectoring
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 42;
  localparam int CORDIC_SCALE = 40;
  localparam int ACC_W        = 32;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic [ACC_W-1:0] ACC_QUARTER   = 32'h4000_0000;
  localparam logic [ACC_W-1:0] ACC_HALF      = 32'h8000_0000;
  localparam logic [ACC_W-1:0] ACC_3_QUARTER = 32'hC000_0000;

  // magnitude sequence slots inside the cordic run
  localparam logic [STEP_W-1:0] STEP_SUM       = 5'd0;
  localparam logic [STEP_W-1:0] STEP_MUL1      = 5'd1;
  localparam logic [STEP_W-1:0] STEP_MUL2      = 5'd2;
  localparam logic [STEP_W-1:0] STEP_ROOT_INIT = 5'd3;
  localparam int               STEP_ROOT      = 4;

  // controller to datapath commands
  typedef struct packed {
    logic              load_in;
    logic              prep_en;
    logic              cordic_en;
    logic              sum_en;
    logic              mul1_en;
    logic              mul2_en;
    logic              root_init;
    logic              root_en;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } sjpp_cmd_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ACC_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [ACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458908;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/smoothed_joystick_polar_packer_unit.sv
// ----------------------------------------------------------------------------
// smoothed_joystick_polar_packer_unit
// Smooths a joystick sample per axis and packs its polar form (speed flag,
// magnitude, angle) into one 16-bit word.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   in      | input     | in_valid, in_ready, in_x_pos, in_y_pos
//   out     | output    | out_valid, out_ready, out_packed_word,
//           |           | out_magnitude_code, out_angle_code
//   cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// From the accepting edge to the output register: the filter updates at the
// accepting edge, then the squares are registered, the cordic steps run (the
// magnitude multiplies and square root run alongside) and the packed word is
// loaded. A new word is accepted only when the sequencer is back in idle.
// Reset clears the filter state and the handshakes and sets the config
// registers to their defaults (alpha 205, speed flag set).
// A stalled result sits in the output register; a new word is taken in
// meanwhile and holds at packing until the register frees.
// Config writes are always ready.
// ----------------------------------------------------------------------------
module smoothed_joystick_polar_packer_unit
  import sjpp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int MAG_BITS     = MAG_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x_pos,
  input  logic signed [SAMPLE_WIDTH-1:0] in_y_pos,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic        [PACKED_W-1:0]     out_packed_word,
  output logic        [MAG_BITS-1:0]     out_magnitude_code,
  output logic        [ANGLE_BITS-1:0]   out_angle_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic        [CFG_IDX_W-1:0]    cfg_index,
  input  logic        [CFG_DATA_W-1:0]   cfg_data
);

  sjpp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // sequencer
  sjpp_ctrl #(
    .MAG_BITS (MAG_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic
  sjpp_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ANGLE_BITS   (ANGLE_BITS),
    .MAG_BITS     (MAG_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_x_pos           (in_x_pos),
    .in_y_pos           (in_y_pos),
    .out_packed_word    (out_packed_word),
    .out_magnitude_code (out_magnitude_code),
    .out_angle_code     (out_angle_code)
  );

endmodule

FILE: design/sjpp_ctrl.sv
// ----------------------------------------------------------------------------
// sjpp_ctrl
// Sequencer: accepts a word, steps the datapath through squaring, the
// cordic run with the magnitude sequence alongside, and the output load.
// ----------------------------------------------------------------------------
module sjpp_ctrl
  import sjpp_pkg::*;
#(
  parameter int MAG_BITS = MAG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sjpp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQR  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] STEP_ROOT_LO   = STEP_W'(STEP_ROOT);
  localparam logic [STEP_W-1:0] STEP_ROOT_END  = STEP_W'(STEP_ROOT + MAG_BITS + 1);

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc;
  logic              run;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign run       = (state_r == ST_RUN);

  // commands
  always_comb begin
    cmd           = '0;
    cmd.load_in   = in_acc;
    cmd.prep_en   = (state_r == ST_SQR);
    cmd.cordic_en = run;
    cmd.sum_en    = run && (step_r == STEP_SUM);
    cmd.mul1_en   = run && (step_r == STEP_MUL1);
    cmd.mul2_en   = run && (step_r == STEP_MUL2);
    cmd.root_init = run && (step_r == STEP_ROOT_INIT);
    cmd.root_en   = run && (step_r >= STEP_ROOT_LO) && (step_r < STEP_ROOT_END);
    cmd.out_load  = (state_r == ST_FIN) && (!out_valid_r || out_ready);
    cmd.step      = step_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SQR;
      end
      ST_SQR: begin
        state_nxt = ST_RUN;
        step_nxt  = '0;
      end
      ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (cmd.out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/sjpp_dpath.sv
// ----------------------------------------------------------------------------
// sjpp_dpath
// Datapath: config registers, per-axis low-pass filter, squared radius,
// bit-serial square root for the magnitude, cordic vectoring for the angle,
// and the output word register.
// ----------------------------------------------------------------------------
module sjpp_dpath
  import sjpp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int MAG_BITS     = MAG_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sjpp_cmd_t                      cmd,
  input  logic                           cfg_we,
  input  logic        [CFG_IDX_W-1:0]    cfg_index,
  input  logic        [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x_pos,
  input  logic signed [SAMPLE_WIDTH-1:0] in_y_pos,
  output logic        [PACKED_W-1:0]     out_packed_word,
  output logic        [MAG_BITS-1:0]     out_magnitude_code,
  output logic        [ANGLE_BITS-1:0]   out_angle_code
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = SW + ALPHA_W + 2;
  localparam int SQW = 2 * SW - 1;
  localparam int R2W = 2 * SW;
  localparam int E   = 2 * SW - 4;
  localparam int MW  = MAG_BITS + 1;
  localparam int P1W = E + MW;
  localparam int P2W = E + 2 * MW;
  localparam int QW  = 2 * MW;
  localparam int SHL = CORDIC_SCALE - SW;
  localparam int WW  = ANGLE_BITS + MAG_BITS + 1;
  localparam logic [MAG_BITS-1:0] MAG_TOP  = MAG_BITS'((2 ** MAG_BITS) - 1);
  localparam logic [MW-1:0]       MAG_MULT = MW'((2 ** MW) - 2);

  // config registers
  logic [ALPHA_W-1:0] alpha_r;
  logic               speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      speed_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ALPHA) begin
        alpha_r <= (cfg_data > ALPHA_MAX) ? ALPHA_MAX : cfg_data[ALPHA_W-1:0];
      end else if (cfg_index == CFG_SPEED) begin
        speed_r <= cfg_data[0];
      end
    end
  end

  // low-pass filter, one lane per axis
  logic signed [SW-1:0] in_s     [2];
  logic signed [SW-1:0] filt_r   [2];
  logic signed [SW-1:0] filt_nxt [2];
  logic signed [SW:0]   diff     [2];
  logic signed [PW-1:0] prod     [2];
  logic signed [PW-1:0] fstep    [2];

  assign in_s[0] = in_x_pos;
  assign in_s[1] = in_y_pos;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      diff[a]     = (SW+1)'(in_s[a]) - (SW+1)'(filt_r[a]);
      prod[a]     = PW'($signed({1'b0, alpha_r})) * PW'(diff[a]);
      fstep[a]    = (prod[a] + PW'(FILT_ROUND)) >>> FILT_SHIFT;
      filt_nxt[a] = SW'(PW'(filt_r[a]) + fstep[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r[0] <= '0;
      filt_r[1] <= '0;
    end else if (cmd.load_in) begin
      filt_r[0] <= filt_nxt[0];
      filt_r[1] <= filt_nxt[1];
    end
  end

  // squares of the filtered axes
  logic signed [R2W-1:0] sq [2];
  logic [SQW-1:0]        sq_r [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sq[a] = R2W'(filt_r[a]) * R2W'(filt_r[a]);
    end
  end

  // squared radius, clamp flag, scaling by (2*top)^2
  logic [R2W-1:0] r2_sum;
  logic [E-1:0]   r2_r;
  logic           sat_r;
  logic [P1W-1:0] p1_r;
  logic [P2W-1:0] p2_r;

  assign r2_sum = R2W'(sq_r[0]) + R2W'(sq_r[1]);

  always_ff @(posedge clk) begin
    if (cmd.prep_en) begin
      sq_r[0] <= sq[0][SQW-1:0];
      sq_r[1] <= sq[1][SQW-1:0];
    end
    if (cmd.sum_en) begin
      r2_r  <= r2_sum[E-1:0];
      sat_r <= |r2_sum[R2W-1:E];
    end
    if (cmd.mul1_en) p1_r <= P1W'(r2_r) * P1W'(MAG_MULT);
    if (cmd.mul2_en) p2_r <= P2W'(p1_r) * P2W'(MAG_MULT);
  end

  // bit-serial integer square root, one result bit a cycle
  logic [QW-1:0] rem_r, root_r, rbit_r;
  logic [QW:0]   trial;

  assign trial = (QW+1)'(root_r) + (QW+1)'(rbit_r);

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rem_r  <= p2_r[P2W-1:E];
      root_r <= '0;
      rbit_r <= QW'(1) << (QW - 2);
    end else if (cmd.root_en) begin
      if ((QW+1)'(rem_r) >= trial) begin
        rem_r  <= rem_r - trial[QW-1:0];
        root_r <= (root_r >> 1) + rbit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      rbit_r <= rbit_r >> 2;
    end
  end

  // cordic: quadrant fold, then vectoring steps
  logic signed [CORDIC_W-1:0] u_r, w_r;
  logic        [ACC_W-1:0]    acc_r;
  logic signed [CORDIC_W-1:0] u0, w0, uq, wq;
  logic        [ACC_W-1:0]    accq;
  logic signed [CORDIC_W-1:0] du, dw;
  logic        [ACC_W-1:0]    atan_v;

  always_comb begin
    u0 = CORDIC_W'(filt_r[1]);
    w0 = CORDIC_W'(filt_r[0]);
    uq = u0;
    wq = w0;
    accq = '0;
    priority if (u0 <= 0 && w0 > 0) begin
      uq = w0;
      wq = -u0;
      accq = ACC_QUARTER;
    end else if (u0 < 0 && w0 <= 0) begin
      uq = -u0;
      wq = -w0;
      accq = ACC_HALF;
    end else if (u0 >= 0 && w0 < 0) begin
      uq = -w0;
      wq = u0;
      accq = ACC_3_QUARTER;
    end else begin
      accq = '0;
    end
  end

  assign du     = w_r >>> cmd.step;
  assign dw     = u_r >>> cmd.step;
  assign atan_v = atan_turn(cmd.step);

  always_ff @(posedge clk) begin
    if (cmd.prep_en) begin
      u_r   <= uq <<< SHL;
      w_r   <= wq <<< SHL;
      acc_r <= accq;
    end else if (cmd.cordic_en && (w_r != '0)) begin
      if (!w_r[CORDIC_W-1]) begin
        u_r   <= u_r + du;
        w_r   <= w_r - dw;
        acc_r <= acc_r + atan_v;
      end else begin
        u_r   <= u_r - du;
        w_r   <= w_r + dw;
        acc_r <= acc_r - atan_v;
      end
    end
  end

  // rounding, clamp and packing
  logic [MW:0]            rnd;
  logic [MW-1:0]          mag_r1;
  logic [MAG_BITS-1:0]    mag_c;
  logic [ANGLE_BITS-1:0]  ang_c;
  logic [WW-1:0]          word_c;
  logic [31:0]            word_ext;

  always_comb begin
    rnd    = (MW+1)'(root_r[MW-1:0]) + (MW+1)'(1);
    mag_r1 = rnd[MW:1];
    if (sat_r) begin
      mag_c = MAG_TOP;
    end else if (mag_r1 > MW'(MAG_TOP)) begin
      mag_c = MAG_TOP;
    end else begin
      mag_c = mag_r1[MAG_BITS-1:0];
    end
    ang_c    = (mag_c == '0) ? '0 : acc_r[ACC_W-1 -: ANGLE_BITS];
    word_c   = {speed_r, mag_c, ang_c};
    word_ext = 32'(word_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_packed_word    <= word_ext[PACKED_W-1:0];
      out_magnitude_code <= mag_c;
      out_angle_code     <= ang_c;
    end
  end

endmodule
